[rtl/scpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared constants and controller/datapath interface types for the
// second-chance page replacement unit.
// ----------------------------------------------------------------------------
package scpr_pkg;

   localparam int FRAMES_DEFAULT    = 16;
   localparam int PAGE_BITS_DEFAULT = 20;

   localparam int PAGE_NUMBER_W = 20;
   localparam int FRAME_INDEX_W = 4;
   localparam int COUNT_W       = 32;
   localparam int CSR_W         = 5;

   localparam logic [CSR_W-1:0] FRAMES_IN_USE_RESET = CSR_W'(16);

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the request page, restart the search
      logic count_req;   // bump the request count
      logic scan_step;   // issue the next frame read, advance the compare stage
      logic hit_commit;  // set the reference bit of the matching frame
      logic count_miss;  // bump the miss count
      logic fill;        // load the page into the next empty frame
      logic hand_init;   // wrap the hand if it lies beyond the frames in use
      logic sweep_step;  // clear the reference bit under the hand, advance
      logic replace;     // load the page at the hand, advance once more
   } scpr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic page_zero;
      logic search_empty;
      logic match;
      logic scan_miss;
      logic can_fill;
      logic hand_ref;
   } scpr_status_type;

endpackage

[rtl/scpr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scpr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scpr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_ctrl
// Sequencer: search, hit update, fill or clock-hand sweep, result strobe.
// ----------------------------------------------------------------------------
module scpr_ctrl
   import scpr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_strobe,
   output scpr_cmd_type    cmd,
   input  scpr_status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      SCAN,
      HIT,
      MISS,
      SWEEP,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.page_zero) begin
               state_in = IDLE;
            end else begin
               cmd.count_req = 1'b1;
               state_in      = status.search_empty ? MISS : SCAN;
            end
         end
         SCAN: begin
            if (status.match) begin
               state_in = HIT;
            end else if (status.scan_miss) begin
               state_in = MISS;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         HIT: begin
            cmd.hit_commit = 1'b1;
            state_in       = EMIT;
         end
         MISS: begin
            cmd.count_miss = 1'b1;
            if (status.can_fill) begin
               cmd.fill = 1'b1;
               state_in = EMIT;
            end else begin
               cmd.hand_init = 1'b1;
               state_in      = SWEEP;
            end
         end
         SWEEP: begin
            if (status.hand_ref) begin
               cmd.sweep_step = 1'b1;
            end else begin
               cmd.replace = 1'b1;
               state_in    = EMIT;
            end
         end
         EMIT: begin
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= (state_in != IDLE);
         strobe_ff <= (state_in == EMIT);
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

[rtl/scpr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpr_dp
// Datapath: frame page RAM, reference bits, fill count, clock hand,
// saturating counters and result registers.
// ----------------------------------------------------------------------------
module scpr_dp
   import scpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_W-1:0]         csr_write_data,
   input  logic [PAGE_NUMBER_W-1:0] req_page_number,
   input  scpr_cmd_type             cmd,
   output scpr_status_type          status,
   output logic                     rsp_fault,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic [COUNT_W-1:0]       rsp_request_total,
   output logic [COUNT_W-1:0]       rsp_miss_total
);

   localparam int IW = $clog2(FRAMES);
   localparam int NW = $clog2(FRAMES + 1);

   logic [CSR_W-1:0]     frames_in_use_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [FRAMES-1:0]    ref_ff;
   logic [NW-1:0]        filled_ff;
   logic [IW-1:0]        hand_ff;
   logic [COUNT_W-1:0]   req_count_ff;
   logic [COUNT_W-1:0]   miss_count_ff;
   logic [NW-1:0]        rd_idx_ff;
   logic [NW-1:0]        cmp_idx_ff;
   logic                 cmp_valid_ff;
   logic                 fault_ff;
   logic [IW-1:0]        frame_ff;

   logic [PAGE_BITS+PAGE_NUMBER_W-1:0] page_ext;
   logic [PAGE_BITS-1:0]               page_in;
   logic [IW+FRAME_INDEX_W-1:0]        frame_ext;
   logic [NW-1:0]                      active_n;
   logic [NW-1:0]                      searched;
   logic [NW-1:0]                      hand_next;
   logic                               rd_issue;
   logic                               ram_we;
   logic [IW-1:0]                      ram_waddr;
   logic [PAGE_BITS-1:0]               ram_rdata;

   // keep only the low PAGE_BITS of the request, zero-extend when wider
   assign page_ext = {{PAGE_BITS{1'b0}}, req_page_number};
   assign page_in  = page_ext[PAGE_BITS-1:0];

   // clamp the register into 1..FRAMES
   always_comb begin
      if (frames_in_use_ff == '0) begin
         active_n = NW'(1);
      end else if (32'(frames_in_use_ff) > 32'(FRAMES)) begin
         active_n = NW'(FRAMES);
      end else begin
         active_n = NW'(frames_in_use_ff);
      end
   end

   assign searched  = (filled_ff < active_n) ? filled_ff : active_n;
   assign hand_next = (NW'(hand_ff) + NW'(1) == active_n) ? '0 : NW'(hand_ff) + NW'(1);
   assign rd_issue  = cmd.scan_step && (rd_idx_ff < searched);

   assign status.page_zero    = (page_ff == '0);
   assign status.search_empty = (searched == '0);
   assign status.match        = cmp_valid_ff && (ram_rdata == page_ff);
   assign status.scan_miss    = cmp_valid_ff && (ram_rdata != page_ff)
                                && (cmp_idx_ff + NW'(1) == searched);
   assign status.can_fill     = (filled_ff < active_n);
   assign status.hand_ref     = ref_ff[hand_ff];

   assign ram_we    = cmd.fill || cmd.replace;
   assign ram_waddr = cmd.fill ? filled_ff[IW-1:0] : hand_ff;

   scpr_ram #(
      .WIDTH(PAGE_BITS),
      .DEPTH(FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (page_ff),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RESET;
         ref_ff           <= '0;
         filled_ff        <= '0;
         hand_ff          <= '0;
         req_count_ff     <= '0;
         miss_count_ff    <= '0;
         cmp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            frames_in_use_ff <= csr_write_data;
         end
         if (cmd.load) begin
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            cmp_valid_ff <= rd_issue;
         end
         if (cmd.count_req && req_count_ff != '1) begin
            req_count_ff <= req_count_ff + COUNT_W'(1);
         end
         if (cmd.count_miss && miss_count_ff != '1) begin
            miss_count_ff <= miss_count_ff + COUNT_W'(1);
         end
         if (cmd.hit_commit) begin
            ref_ff[cmp_idx_ff[IW-1:0]] <= 1'b1;
         end
         if (cmd.fill) begin
            ref_ff[filled_ff[IW-1:0]] <= 1'b0;
            filled_ff                 <= filled_ff + NW'(1);
         end
         if (cmd.hand_init && NW'(hand_ff) >= active_n) begin
            hand_ff <= '0;
         end
         if (cmd.sweep_step) begin
            ref_ff[hand_ff] <= 1'b0;
            hand_ff         <= hand_next[IW-1:0];
         end
         if (cmd.replace) begin
            ref_ff[hand_ff] <= 1'b0;
            hand_ff         <= hand_next[IW-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff   <= page_in;
         rd_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         rd_idx_ff <= rd_idx_ff + NW'(rd_issue);
      end
      if (rd_issue) begin
         cmp_idx_ff <= rd_idx_ff;
      end
      if (cmd.hit_commit) begin
         fault_ff <= 1'b0;
         frame_ff <= cmp_idx_ff[IW-1:0];
      end
      if (cmd.fill) begin
         fault_ff <= 1'b1;
         frame_ff <= filled_ff[IW-1:0];
      end
      if (cmd.replace) begin
         fault_ff <= 1'b1;
         frame_ff <= hand_ff;
      end
   end

   assign frame_ext         = {{FRAME_INDEX_W{1'b0}}, frame_ff};
   assign rsp_fault         = fault_ff;
   assign rsp_frame_index   = frame_ext[FRAME_INDEX_W-1:0];
   assign rsp_request_total = req_count_ff;
   assign rsp_miss_total    = miss_count_ff;

endmodule

[rtl/second_chance_page_replacement_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_chance_page_replacement_unit
// Clock (second-chance) page replacement with a sequential frame search.
// ----------------------------------------------------------------------------
// A zero page raises busy for a single cycle and gives no result. A hit reads
//   the frames in fill order up to the match; a miss loads a free frame or,
//   with all frames in use filled, sweeps the hand, clearing set reference bits.
// Throughput: one request at a time; one page RAM read or one reference bit
//   per cycle, and the next request is taken the cycle after the strobe.
// Reset: synchronous; clears counters, fill count, hand and reference bits.
module second_chance_page_replacement_unit
   import scpr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [PAGE_NUMBER_W-1:0] req_page_number,
   output logic                     rsp_strobe,
   output logic                     rsp_fault,
   output logic [FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic [COUNT_W-1:0]       rsp_request_total,
   output logic [COUNT_W-1:0]       rsp_miss_total,
   input  logic                     csr_write_enable,
   input  logic [CSR_W-1:0]         csr_write_data
);

   scpr_cmd_type    cmd;
   scpr_status_type status;

   scpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   scpr_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_page_number   (req_page_number),
      .cmd               (cmd),
      .status            (status),
      .rsp_fault         (rsp_fault),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_request_total (rsp_request_total),
      .rsp_miss_total    (rsp_miss_total)
   );

   // a transaction never strobes twice in a row
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // a hit leaves the miss count untouched
   a_hit_no_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_fault) |-> (rsp_miss_total == $past(rsp_miss_total)))
      else $error("miss count moved on a hit");

   a_one_cmd_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill && cmd.replace))
      else $error("fill and replace issued together");

endmodule
